### rtl/assert_macros.svh
// Assertion macros shared by the line stepper RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same, for a property that must hold even during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/als_pkg.sv
// Package for the antialiased line stepper: widths, codes, command/status types.
// No dependencies.
package als_pkg;

    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 24;
    localparam int ALPHA_W     = 8;
    localparam int ACC_W       = 22;
    localparam int INC_W       = 17;
    localparam int FRAC_BITS   = 16;
    localparam int ALPHA_SHIFT = 8;
    localparam int DIV_STEPS   = ACC_W;
    localparam int DIV_CNT_W   = 5;

    localparam logic [COORD_W-1:0] MAX_COORD  = 6'd63;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

    localparam logic KIND_ENDPOINT = 1'b0;
    localparam logic KIND_STEP     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ENDPT,
        ST_STEP
    } als_state_t;

    typedef struct packed {
        logic load;
        logic emit_end;
        logic emit_step;
    } als_cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic steps_one;
    } als_stat_t;

    function automatic logic [COORD_W-1:0] clamp_in(input logic [COORD_W-1:0] v);
        return (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_s(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] lim;
        lim = $signed({2'b00, MAX_COORD});
        if (v < 0)
            return '0;
        else if (v > lim)
            return MAX_COORD;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

### rtl/als_divider.sv
// Restoring divider, one quotient bit per cycle: (minor << 16) / major.
// Depends on als_pkg.
module als_divider import als_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COORD_W-1:0] minor,
    input  logic [COORD_W-1:0] major,
    output logic               done,
    output logic [INC_W-1:0]   quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0]   div_reg, div_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [ACC_W-1:0]     dvd_reg, dvd_next;
    logic [INC_W-1:0]     quo_reg, quo_next;
    logic [COORD_W:0]     trial;
    logic                 qbit;

    assign trial = {rem_reg, dvd_reg[ACC_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});
    assign done  = busy_reg && (cnt_reg == DIV_CNT_W'(1));
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            div_next  = major;
            rem_next  = '0;
            dvd_next  = {minor, {FRAC_BITS{1'b0}}};
            quo_next  = '0;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits in the coordinate width
            rem_next = qbit ? COORD_W'(trial - {1'b0, div_reg}) : trial[COORD_W-1:0];
            dvd_next = {dvd_reg[ACC_W-2:0], 1'b0};
            quo_next = {quo_reg[INC_W-2:0], qbit};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        div_reg <= div_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

endmodule

### rtl/als_datapath.sv
// Datapath of the line stepper: segment setup, error accumulator, result register.
// Depends on als_pkg; takes its increment from als_divider.
module als_datapath import als_pkg::*; (
    input  logic               aclk,
    input  als_cmd_t           cmd,
    output als_stat_t          stat,
    input  logic [COORD_W-1:0] in_start_x,
    input  logic [COORD_W-1:0] in_start_y,
    input  logic [COORD_W-1:0] in_end_x,
    input  logic [COORD_W-1:0] in_end_y,
    input  logic [COLOR_W-1:0] in_color,
    output logic [COORD_W-1:0] div_minor,
    output logic [COORD_W-1:0] div_major,
    input  logic [INC_W-1:0]   increment,
    output logic               out_kind,
    output logic [COORD_W-1:0] out_main_x,
    output logic [COORD_W-1:0] out_main_y,
    output logic [ALPHA_W-1:0] out_main_alpha,
    output logic [COORD_W-1:0] out_side_x,
    output logic [COORD_W-1:0] out_side_y,
    output logic [ALPHA_W-1:0] out_side_alpha,
    output logic [COLOR_W-1:0] out_color,
    output logic               out_last
);

    // setup, combinational from the input ports
    logic [COORD_W-1:0] cx0, cy0, cx1, cy1;
    logic [COORD_W-1:0] ux, uy, lx, ly;
    logic [COORD_W-1:0] adx, ady;
    logic               left_c, ymaj_c;

    assign cx0 = clamp_in(in_start_x);
    assign cy0 = clamp_in(in_start_y);
    assign cx1 = clamp_in(in_end_x);
    assign cy1 = clamp_in(in_end_y);

    always_comb begin
        if (cy0 > cy1) begin
            ux = cx1; uy = cy1; lx = cx0; ly = cy0;
        end else begin
            ux = cx0; uy = cy0; lx = cx1; ly = cy1;
        end
        left_c = (lx < ux);
        adx    = left_c ? ux - lx : lx - ux;
        ady    = ly - uy;
        ymaj_c = (ady > adx);
    end

    assign div_major = ymaj_c ? ady : adx;
    assign div_minor = ymaj_c ? adx : ady;

    logic [COORD_W-1:0] bx_reg, by_reg, ex_reg, ey_reg, steps_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               left_reg, ymaj_reg;

    logic               kind_reg;
    logic [COORD_W-1:0] mx_reg, my_reg, sx_reg, sy_reg;
    logic [ALPHA_W-1:0] ma_reg, sa_reg;
    logic [COLOR_W-1:0] oc_reg;
    logic               last_reg;

    assign stat.steps_zero = (steps_reg == '0);
    assign stat.steps_one  = (steps_reg == COORD_W'(1));

    // one major-axis step
    logic [ACC_W-1:0]          acc_n;
    logic [COORD_W-1:0]        whole;
    logic [ALPHA_W-1:0]        frac;
    logic signed [COORD_W+1:0] bx8, by8, wh8, m_x, m_y, s_x, s_y;
    logic [COORD_W-1:0]        bx_step, by_step;

    always_comb begin
        acc_n = acc_reg + ACC_W'(increment);
        whole = acc_n[ACC_W-1:FRAC_BITS];
        frac  = acc_n[FRAC_BITS-1:ALPHA_SHIFT];
        bx8   = $signed({2'b00, bx_reg});
        by8   = $signed({2'b00, by_reg});
        wh8   = $signed({2'b00, whole});
        if (ymaj_reg) begin
            bx_step = bx_reg;
            by_step = by_reg + COORD_W'(1);
            m_y     = $signed({2'b00, by_step});
            s_y     = m_y;
            m_x     = left_reg ? bx8 - wh8 : bx8 + wh8;
            s_x     = left_reg ? m_x - 8'sd1 : m_x + 8'sd1;
        end else begin
            bx_step = left_reg ? bx_reg - COORD_W'(1) : bx_reg + COORD_W'(1);
            by_step = by_reg;
            m_x     = $signed({2'b00, bx_step});
            s_x     = m_x;
            m_y     = by8 + wh8;
            s_y     = m_y + 8'sd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bx_reg    <= ux;
            by_reg    <= uy;
            ex_reg    <= lx;
            ey_reg    <= ly;
            left_reg  <= left_c;
            ymaj_reg  <= ymaj_c;
            acc_reg   <= '0;
            color_reg <= in_color;
            steps_reg <= (div_major > COORD_W'(1)) ? div_major - COORD_W'(1) : '0;
        end else if (cmd.emit_step) begin
            bx_reg    <= bx_step;
            by_reg    <= by_step;
            acc_reg   <= acc_n;
            steps_reg <= steps_reg - COORD_W'(1);
        end

        if (cmd.emit_end) begin
            kind_reg <= KIND_ENDPOINT;
            mx_reg   <= bx_reg;
            my_reg   <= by_reg;
            ma_reg   <= ALPHA_FULL;
            sx_reg   <= ex_reg;
            sy_reg   <= ey_reg;
            sa_reg   <= ALPHA_FULL;
            oc_reg   <= color_reg;
            last_reg <= stat.steps_zero;
        end else if (cmd.emit_step) begin
            kind_reg <= KIND_STEP;
            mx_reg   <= clamp_s(m_x);
            my_reg   <= clamp_s(m_y);
            ma_reg   <= ALPHA_FULL - frac;
            sx_reg   <= clamp_s(s_x);
            sy_reg   <= clamp_s(s_y);
            sa_reg   <= frac;
            oc_reg   <= color_reg;
            last_reg <= stat.steps_one;
        end
    end

    assign out_kind       = kind_reg;
    assign out_main_x     = mx_reg;
    assign out_main_y     = my_reg;
    assign out_main_alpha = ma_reg;
    assign out_side_x     = sx_reg;
    assign out_side_y     = sy_reg;
    assign out_side_alpha = sa_reg;
    assign out_color      = oc_reg;
    assign out_last       = last_reg;

endmodule

### rtl/als_ctrl.sv
// Controller of the line stepper: segment sequencing and result valid flag.
// Depends on als_pkg and assert_macros.svh.
`include "assert_macros.svh"
module als_ctrl import als_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  logic      div_done,
    input  als_stat_t stat,
    output als_cmd_t  cmd
);

    als_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done)
                    state_next = ST_ENDPT;
            end
            ST_ENDPT: begin
                if (out_free) begin
                    cmd.emit_end = 1'b1;
                    state_next   = stat.steps_zero ? ST_IDLE : ST_STEP;
                end
            end
            ST_STEP: begin
                if (out_free) begin
                    cmd.emit_step = 1'b1;
                    if (stat.steps_one)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // a new result replaces the one taken at this edge
        if (cmd.emit_end || cmd.emit_step)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    assign m_valid = m_valid_reg;

    `ASSERT_CLK(a_no_overwrite, aclk, aresetn,
        (cmd.emit_end || cmd.emit_step) |-> (!m_valid_reg || m_ready),
        "result register overwritten while a transfer is pending")
    `ASSERT_CLK(a_done_in_div, aclk, aresetn, div_done |-> (state_reg == ST_DIV),
        "divider finished outside the divide state")
    `ASSERT_CLK(a_step_count, aclk, aresetn, cmd.emit_step |-> !stat.steps_zero,
        "step emitted with no steps left")
    `ASSERT_CLK(a_valid_held, aclk, aresetn, (m_valid_reg && !m_ready) |=> m_valid_reg,
        "result valid dropped before its transfer")

endmodule

### rtl/antialiased_line_stepper_top.sv
// Antialiased line stepper (Wu style), top level.
// Depends on als_pkg, als_ctrl, als_datapath and als_divider.
//
// Usage:
//   Input channel s_*: one line segment per transfer (two 6-bit endpoints and a
//   24-bit colour). Output channel m_*: the results of that segment, the
//   endpoint pair first (kind 0) and then one result per inner major-axis step
//   (kind 1), m_last marking the final one of the segment.
//   The endpoint result is issued once the 17-bit increment is ready; it
//   comes from a restoring divider that retires one bit of the 22-bit
//   dividend per cycle. Step results then follow one per cycle while the
//   receiver does not stall, one accumulator add each.
//   s_ready is high only between segments; it rises once the last result is
//   in the output register, so the next segment is taken while that result
//   still waits for its transfer.
//   A stalled receiver holds the output register and freezes the stepping.
//   Reset (aresetn low, synchronous) clears the controller and divider state;
//   no result is pending afterwards.
module antialiased_line_stepper_top import als_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_start_x,
    input  logic [COORD_W-1:0] s_start_y,
    input  logic [COORD_W-1:0] s_end_x,
    input  logic [COORD_W-1:0] s_end_y,
    input  logic [COLOR_W-1:0] s_line_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [COORD_W-1:0] m_main_x,
    output logic [COORD_W-1:0] m_main_y,
    output logic [ALPHA_W-1:0] m_main_alpha,
    output logic [COORD_W-1:0] m_side_x,
    output logic [COORD_W-1:0] m_side_y,
    output logic [ALPHA_W-1:0] m_side_alpha,
    output logic [COLOR_W-1:0] m_pixel_color,
    output logic               m_last
);

    als_cmd_t           cmd;
    als_stat_t          stat;
    logic               div_done;
    logic [COORD_W-1:0] div_minor, div_major;
    logic [INC_W-1:0]   increment;

    als_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_done (div_done),
        .stat     (stat),
        .cmd      (cmd)
    );

    als_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load),
        .minor    (div_minor),
        .major    (div_major),
        .done     (div_done),
        .quotient (increment)
    );

    als_datapath u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .stat           (stat),
        .in_start_x     (s_start_x),
        .in_start_y     (s_start_y),
        .in_end_x       (s_end_x),
        .in_end_y       (s_end_y),
        .in_color       (s_line_color),
        .div_minor      (div_minor),
        .div_major      (div_major),
        .increment      (increment),
        .out_kind       (m_kind),
        .out_main_x     (m_main_x),
        .out_main_y     (m_main_y),
        .out_main_alpha (m_main_alpha),
        .out_side_x     (m_side_x),
        .out_side_y     (m_side_y),
        .out_side_alpha (m_side_alpha),
        .out_color      (m_pixel_color),
        .out_last       (m_last)
    );

endmodule
